### rtl/core/euler_to_dcm_top_macros.svh
//------------------------------------------------------------------------------
// euler_to_dcm_top_macros
// assertion macros for the euler to dcm block
//------------------------------------------------------------------------------
`ifndef EULER_TO_DCM_TOP_MACROS_SVH
`define EULER_TO_DCM_TOP_MACROS_SVH
// implication checked every clock, off during reset
`define ETD_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define ETD_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### rtl/core/etd_pkg.sv
//------------------------------------------------------------------------------
// etd_pkg
// constants, types and tables shared by the euler to dcm block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package etd_pkg;
    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_BITS      = OUT_FRAC_BITS + 2;
    localparam int CORDIC_ITERS  = 30;
    localparam int VAL_BITS      = 33;
    localparam logic signed [VAL_BITS-1:0] GAIN_INV = 33'sd652032874;

    typedef logic signed [VAL_BITS-1:0] t_val;

    typedef struct packed {
        t_val cos_v;
        t_val sin_v;
    } t_sc;

    function automatic logic signed [33:0] atan_entry(input int idx);
        logic [31:0] t;
        unique case (idx)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return $signed({2'b00, t});
    endfunction

    // product of two q30 values, rounded back to q30
    function automatic t_val qmul(input t_val a, input t_val b);
        logic signed [65:0] p;
        p = a * b + 66'sd536870912;
        return t_val'(p >>> 30);
    endfunction
endpackage

### rtl/core/etd_sincos.sv
//------------------------------------------------------------------------------
// etd_sincos
// pipelined cordic sine and cosine, one rotation per stage
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module etd_sincos
    import etd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_sc                   o_sc
);
    localparam int NS = CORDIC_ITERS;

    logic [31:0]        w_turn;
    logic [1:0]         w_q;
    logic [31:0]        w_d;
    t_val               r_x [NS+1];
    t_val               r_y [NS+1];
    logic signed [33:0] r_z [NS+1];
    logic [1:0]         r_q [NS+1];
    t_sc                r_sc;

    assign w_turn = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_q    = 2'((w_turn + 32'h20000000) >> 30);
    assign w_d    = w_turn - {w_q, 30'd0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= GAIN_INV;
        r_y[0] <= '0;
        r_z[0] <= 34'(signed'(w_d));
        r_q[0] <= w_q;
    end

    // one cordic rotation per register stage
    for (genvar i = 0; i < NS; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            r_q[i+1] <= r_q[i];
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_entry(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_entry(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_q[NS])
            2'd0: begin r_sc.cos_v <= r_x[NS];  r_sc.sin_v <= r_y[NS];  end
            2'd1: begin r_sc.cos_v <= -r_y[NS]; r_sc.sin_v <= r_x[NS];  end
            2'd2: begin r_sc.cos_v <= -r_x[NS]; r_sc.sin_v <= -r_y[NS]; end
            default: begin r_sc.cos_v <= r_y[NS]; r_sc.sin_v <= -r_x[NS]; end
        endcase
    end

    assign o_sc = r_sc;
    logic unused_rst;
    assign unused_rst = i_rst_n;
endmodule

### rtl/core/euler_to_dcm_top.sv
// throughput: one transaction every cycle, busy is tied low
// the depth is set by the 30 stage cordic pipeline and three product stages
// reset clears valid bits and the sequence register to 3-2-1
// results are not stalled: the receiver takes each one as it appears
//------------------------------------------------------------------------------
// euler_to_dcm_top
// euler angles to direction cosine matrix, deep pipelined fixed point
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_to_dcm_top_macros.svh"
module euler_to_dcm_top
    import etd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_data,
    input  logic signed [ANGLE_BITS-1:0] i_roll_angle,
    input  logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    output logic                       o_done,
    output logic signed [OUT_BITS-1:0] o_m00, o_m01, o_m02,
    output logic signed [OUT_BITS-1:0] o_m10, o_m11, o_m12,
    output logic signed [OUT_BITS-1:0] o_m20, o_m21, o_m22
);
    // cordic: input reg + 30 rotations + fold = 32; then 3 product stages + output
    localparam int SC_LAT = CORDIC_ITERS + 2;
    localparam int LAT    = SC_LAT + 4;

    logic     r_seq;
    logic     r_vld [LAT];
    logic     r_sq  [SC_LAT+2];
    t_sc      w_s1, w_s2, w_s3;

    // pipeline never stalls
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seq <= 1'b0;
        else if (i_cfg_we) r_seq <= i_cfg_data;
    end

    // valid bits and the sequence select travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= start;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_sq[0] <= r_seq;
        for (int k = 1; k < SC_LAT+2; k++) r_sq[k] <= r_sq[k-1];
    end

    etd_sincos u_roll  (.i_clk, .i_rst_n, .i_angle(i_roll_angle),  .o_sc(w_s1));
    etd_sincos u_pitch (.i_clk, .i_rst_n, .i_angle(i_pitch_angle), .o_sc(w_s2));
    etd_sincos u_yaw   (.i_clk, .i_rst_n, .i_angle(i_yaw_angle),   .o_sc(w_s3));

    // stage a: first products; sin/cos kept for stage b
    t_val r_a [9];
    t_val r_c1, r_s1, r_c3, r_s3, r_s2, r_c2;
    always_ff @(posedge i_clk) begin
        r_c1 <= w_s1.cos_v; r_s1 <= w_s1.sin_v;
        r_c2 <= w_s2.cos_v; r_s2 <= w_s2.sin_v;
        r_c3 <= w_s3.cos_v; r_s3 <= w_s3.sin_v;
        if (!r_sq[SC_LAT-1]) begin
            r_a[0] <= qmul(w_s2.cos_v, w_s3.cos_v);
            r_a[1] <= qmul(w_s2.cos_v, w_s3.sin_v);
            r_a[2] <= qmul(w_s1.sin_v, w_s2.sin_v);
            r_a[3] <= qmul(w_s1.cos_v, w_s3.sin_v);
            r_a[4] <= qmul(w_s1.cos_v, w_s3.cos_v);
            r_a[5] <= qmul(w_s2.cos_v, w_s1.sin_v);
            r_a[6] <= qmul(w_s1.cos_v, w_s2.sin_v);
            r_a[7] <= qmul(w_s1.sin_v, w_s3.sin_v);
            r_a[8] <= qmul(w_s1.sin_v, w_s3.cos_v);
        end else begin
            r_a[0] <= qmul(w_s2.cos_v, w_s3.cos_v);
            r_a[1] <= qmul(w_s2.sin_v, w_s3.cos_v);
            r_a[2] <= qmul(w_s1.sin_v, w_s2.sin_v);
            r_a[3] <= qmul(w_s2.cos_v, w_s3.sin_v);
            r_a[4] <= qmul(w_s3.cos_v, w_s1.cos_v);
            r_a[5] <= qmul(w_s2.sin_v, w_s3.sin_v);
            r_a[6] <= qmul(w_s2.cos_v, w_s1.sin_v);
            r_a[7] <= qmul(w_s2.sin_v, w_s1.cos_v);
            r_a[8] <= qmul(w_s3.cos_v, w_s1.sin_v);
        end
    end

    // stage b: second products
    t_val r_b [9];
    t_val r_p [6];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) r_b[k] <= r_a[k];
        if (!r_sq[SC_LAT]) begin
            r_p[0] <= qmul(r_a[2], r_c3);   // s1 s2 c3
            r_p[1] <= qmul(r_a[2], r_s3);   // s1 s2 s3
            r_p[2] <= qmul(r_a[6], r_c3);   // c1 s2 c3
            r_p[3] <= qmul(r_a[6], r_s3);   // c1 s2 s3
            r_p[4] <= qmul(r_c2, r_c1);
            r_p[5] <= -r_s2;
        end else begin
            r_p[0] <= qmul(r_a[3], r_c1);   // c2 s3 c1
            r_p[1] <= qmul(r_a[5], r_c1);   // s2 s3 c1
            r_p[2] <= qmul(r_a[3], r_s1);   // c2 s3 s1
            r_p[3] <= qmul(r_a[5], r_s1);   // s2 s3 s1
            r_p[4] <= qmul(r_c2, r_c1);
            r_p[5] <= r_s3;
        end
    end

    // stage c: sums into the nine entries
    logic signed [VAL_BITS:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (!r_sq[SC_LAT+1]) begin
            r_m[0] <= 34'(r_b[0]);
            r_m[1] <= 34'(r_b[1]);
            r_m[2] <= 34'(r_p[5]);
            r_m[3] <= 34'(r_p[0]) - 34'(r_b[3]);
            r_m[4] <= 34'(r_p[1]) + 34'(r_b[4]);
            r_m[5] <= 34'(r_b[5]);
            r_m[6] <= 34'(r_p[2]) + 34'(r_b[7]);
            r_m[7] <= 34'(r_p[3]) - 34'(r_b[8]);
            r_m[8] <= 34'(r_p[4]);
        end else begin
            r_m[0] <= 34'(r_b[0]);
            r_m[1] <= 34'(r_p[5]);
            r_m[2] <= -34'(r_b[1]);
            r_m[3] <= 34'(r_b[2]) - 34'(r_p[0]);
            r_m[4] <= 34'(r_b[4]);
            r_m[5] <= 34'(r_p[1]) + 34'(r_b[6]);
            r_m[6] <= 34'(r_p[2]) + 34'(r_b[7]);
            r_m[7] <= -34'(r_b[8]);
            r_m[8] <= 34'(r_p[4]) - 34'(r_p[3]);
        end
    end

    // final rounding to the output format and saturation
    function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [VAL_BITS:0] v);
        localparam int SH = 30 - OUT_FRAC_BITS;
        logic signed [VAL_BITS+1:0] r;
        r = (35'(v) + (35'sd1 <<< (SH-1))) >>> SH;
        if (r > (35'sd1 <<< OUT_FRAC_BITS)) r = 35'sd1 <<< OUT_FRAC_BITS;
        if (r < -(35'sd1 <<< OUT_FRAC_BITS)) r = -(35'sd1 <<< OUT_FRAC_BITS);
        return OUT_BITS'(r);
    endfunction

    logic signed [OUT_BITS-1:0] r_o [9];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) r_o[k] <= finish(r_m[k]);
    end

    assign o_done = r_vld[LAT-1];
    assign o_m00 = r_o[0]; assign o_m01 = r_o[1]; assign o_m02 = r_o[2];
    assign o_m10 = r_o[3]; assign o_m11 = r_o[4]; assign o_m12 = r_o[5];
    assign o_m20 = r_o[6]; assign o_m21 = r_o[7]; assign o_m22 = r_o[8];

    `ETD_ASSERT_IMP(a_busy_low, i_clk, i_rst_n, 1'b1, !busy)
    `ETD_ASSERT_NXT(a_vld_enter, i_clk, i_rst_n, start, r_vld[0])
    `ETD_ASSERT_IMP(a_sat_m00, i_clk, i_rst_n, o_done,
        (o_m00 <= 16'sd16384) && (o_m00 >= -16'sd16384))
endmodule

### dv/euler_to_dcm_checker.sv
//------------------------------------------------------------------------------
// euler_to_dcm_checker
// watches the angle and matrix ports, computes the expected matrix per
// transaction and compares each o_done strobe against the oldest one
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module euler_to_dcm_checker
    import etd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_data,
    input  logic signed [ANGLE_BITS-1:0] i_roll,
    input  logic signed [ANGLE_BITS-1:0] i_pitch,
    input  logic signed [ANGLE_BITS-1:0] i_yaw,
    input  logic                         i_done,
    input  logic signed [OUT_BITS-1:0]   i_m [9],
    output int                           o_errors,
    output int                           o_pending
);
    typedef logic signed [OUT_BITS-1:0] t_entry;
    typedef struct packed {
        t_entry e0, e1, e2, e3, e4, e5, e6, e7, e8;
    } t_dcm;

    localparam logic signed [33:0] ATAN [30] = '{
        34'h20000000, 34'h12E4051E, 34'h09FB385B, 34'h051111D4, 34'h028B0D43,
        34'h0145D7E1, 34'h00A2F61E, 34'h00517C55, 34'h0028BE53, 34'h00145F2F,
        34'h000A2F98, 34'h000517CC, 34'h00028BE6, 34'h000145F3, 34'h0000A2F9,
        34'h0000517D, 34'h000028BE, 34'h0000145F, 34'h00000A30, 34'h00000518,
        34'h0000028C, 34'h00000146, 34'h000000A3, 34'h00000051, 34'h00000029,
        34'h00000014, 34'h0000000A, 34'h00000005, 34'h00000003, 34'h00000001};

    logic   seq_231;
    t_dcm   dcm_queue[$];

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    // cordic sine/cosine with quadrant fold
    function automatic void angle_sincos(logic [ANGLE_BITS-1:0] ang,
                                         output longint c, output longint s);
        logic [31:0] a, d;
        logic [1:0]  q;
        longint      x, y, z, xs, ys;
        a = {ang, {(32-ANGLE_BITS){1'b0}}};
        q = 2'((a + 32'h20000000) >> 30);
        d = a - ({30'b0, q} << 30);
        z = longint'($signed(d));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN[i];
            end else begin
                x += ys; y -= xs; z += ATAN[i];
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_entry to_q14(longint v);
        longint r;
        r = (v + (64'sd1 << (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
        if (r > (64'sd1 << OUT_FRAC_BITS)) r = 64'sd1 << OUT_FRAC_BITS;
        if (r < -(64'sd1 << OUT_FRAC_BITS)) r = -(64'sd1 << OUT_FRAC_BITS);
        return t_entry'(r);
    endfunction

    function automatic t_dcm predict_dcm(logic [ANGLE_BITS-1:0] r,
            logic [ANGLE_BITS-1:0] p, logic [ANGLE_BITS-1:0] w, logic alt);
        longint c1, s1, c2, s2, c3, s3;
        longint m[9];
        t_dcm   res;
        angle_sincos(r, c1, s1);
        angle_sincos(p, c2, s2);
        angle_sincos(w, c3, s3);
        if (!alt) begin
            m[0] = q30_mul(c2, c3);
            m[1] = q30_mul(c2, s3);
            m[2] = -s2;
            m[3] = q30_mul(q30_mul(s1, s2), c3) - q30_mul(c1, s3);
            m[4] = q30_mul(q30_mul(s1, s2), s3) + q30_mul(c1, c3);
            m[5] = q30_mul(c2, s1);
            m[6] = q30_mul(q30_mul(c1, s2), c3) + q30_mul(s1, s3);
            m[7] = q30_mul(q30_mul(c1, s2), s3) - q30_mul(s1, c3);
            m[8] = q30_mul(c2, c1);
        end else begin
            m[0] = q30_mul(c2, c3);
            m[1] = s3;
            m[2] = -q30_mul(s2, c3);
            m[3] = q30_mul(s1, s2) - q30_mul(q30_mul(c2, s3), c1);
            m[4] = q30_mul(c3, c1);
            m[5] = q30_mul(q30_mul(s2, s3), c1) + q30_mul(c2, s1);
            m[6] = q30_mul(q30_mul(c2, s3), s1) + q30_mul(s2, c1);
            m[7] = -q30_mul(c3, s1);
            m[8] = q30_mul(c2, c1) - q30_mul(q30_mul(s2, s3), s1);
        end
        res = {to_q14(m[0]), to_q14(m[1]), to_q14(m[2]), to_q14(m[3]),
               to_q14(m[4]), to_q14(m[5]), to_q14(m[6]), to_q14(m[7]),
               to_q14(m[8])};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_dcm   exp_m;
        t_entry exp_e;
        int     n_err;
        n_err = 0;
        if (!i_rst_n) begin
            seq_231   <= 1'b0;
            o_errors  <= 0;
            o_pending <= 0;
            dcm_queue.delete();
        end else begin
            if (i_start && !i_busy)
                dcm_queue.push_back(predict_dcm(i_roll, i_pitch, i_yaw, seq_231));
            if (i_cfg_we)
                seq_231 <= i_cfg_data;
            if (i_done) begin
                if (dcm_queue.size() == 0) begin
                    $display("%0t: matrix with no transaction pending", $time);
                    n_err = n_err + 1;
                end else begin
                    exp_m = dcm_queue.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        exp_e = exp_m[(8-k)*OUT_BITS +: OUT_BITS];
                        if (exp_e !== i_m[k]) begin
                            $display("%0t: m%0d%0d expected %0d actual %0d",
                                     $time, k / 3, k % 3, exp_e, i_m[k]);
                            n_err = n_err + 1;
                        end
                    end
                end
            end
            o_errors  <= o_errors + n_err;
            o_pending <= dcm_queue.size();
        end
    end
endmodule

### dv/tb_euler_to_dcm_top.sv
//------------------------------------------------------------------------------
// tb_euler_to_dcm_top
// drives angle triples through the euler to dcm block under both rotation
// sequences with random gaps; the checker predicts and compares each matrix
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_euler_to_dcm_top;
    import etd_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_data = 1'b0;
    logic signed [ANGLE_BITS-1:0] i_roll_angle = '0;
    logic signed [ANGLE_BITS-1:0] i_pitch_angle = '0;
    logic signed [ANGLE_BITS-1:0] i_yaw_angle = '0;
    logic                         o_done;
    logic signed [OUT_BITS-1:0]   dcm_out [9];
    int                           errors;
    int                           pending;
    int                           idle_cycles = 0;
    int                           gap_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    euler_to_dcm_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle), .o_done(o_done),
        .o_m00(dcm_out[0]), .o_m01(dcm_out[1]), .o_m02(dcm_out[2]),
        .o_m10(dcm_out[3]), .o_m11(dcm_out[4]), .o_m12(dcm_out[5]),
        .o_m20(dcm_out[6]), .o_m21(dcm_out[7]), .o_m22(dcm_out[8])
    );

    euler_to_dcm_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_roll(i_roll_angle), .i_pitch(i_pitch_angle), .i_yaw(i_yaw_angle),
        .i_done(o_done), .i_m(dcm_out), .o_errors(errors), .o_pending(pending)
    );

    // watchdog: cycles without any accepted transaction or matrix
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one transaction; start stays high across back-to-back ones
    task automatic send_angles(logic [15:0] r, logic [15:0] p, logic [15:0] w);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_roll_angle  <= r;
        i_pitch_angle <= p;
        i_yaw_angle   <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // wait for every pending matrix, then let the pipe empty
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write while idle, sequence select only in bit 0
    task automatic write_sequence(logic seq);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= seq;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // random angle biased toward quadrant edges and extremes
    function automatic logic [15:0] pick_angle();
        logic [15:0] edges [6] = '{16'h8000, 16'h7FFF, 16'h0000,
                                   16'h4000, 16'hC000, 16'h2000};
        case ($urandom_range(7))
            0: return edges[$urandom_range(5)];
            1: return edges[$urandom_range(5)] + 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] dir [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                  16'h4000, 16'hC000, 16'h2000, 16'hE000,
                                  16'h1FFF, 16'h6000, 16'h5555, 16'hAAAA};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and quadrant boundaries under both sequences
        for (int s = 0; s < 2; s++) begin
            write_sequence(s[0]);
            for (int k = 0; k < 12; k++)
                send_angles(dir[k], dir[(k + 5) % 12], dir[(k + 9) % 12]);
            drain_pipe();
        end

        // random phases: sender gap 32, then 67, then none, flipping sequence
        for (int ph = 0; ph < 6; ph++) begin
            gap_pct = (ph % 3 == 0) ? 32 : (ph % 3 == 1) ? 67 : 0;
            write_sequence(ph[0]);
            for (int n = 0; n < 300; n++) begin
                send_angles(pick_angle(), pick_angle(), pick_angle());
                // occasional full pause until every matrix is back
                if (n == 150) drain_pipe();
            end
            drain_pipe();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/etd_pkg.sv
rtl/core/etd_sincos.sv
rtl/core/euler_to_dcm_top.sv
dv/euler_to_dcm_checker.sv
dv/tb_euler_to_dcm_top.sv
